>>> design/rpph_pkg.sv
// ---------------------------------------------------------------------------
// rpph_pkg: shared types and helpers for the ray to panel pixel block
// Register codes, miss codes, pipeline payloads, rounding, range and division helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rpph_pkg;

  localparam int DIV_STEPS = 31;

  localparam logic [3:0] REG_CENTER_X = 4'd0;
  localparam logic [3:0] REG_CENTER_Y = 4'd1;
  localparam logic [3:0] REG_CENTER_Z = 4'd2;
  localparam logic [3:0] REG_NORMAL   = 4'd3;
  localparam logic [3:0] REG_RIGHT    = 4'd4;
  localparam logic [3:0] REG_UP       = 4'd5;
  localparam logic [3:0] REG_INV_EXT  = 4'd6;
  localparam logic [3:0] REG_PIX_EXT  = 4'd7;

  localparam logic [1:0] RSN_HIT      = 2'd0;
  localparam logic [1:0] RSN_PARALLEL = 2'd1;
  localparam logic [1:0] RSN_RANGE    = 2'd2;
  localparam logic [1:0] RSN_OVERFLOW = 2'd3;

  localparam logic signed [40:0] DEN_FLOOR = 41'sd34359;
  localparam logic signed [63:0] HALF_Q24  = 64'sh0000_0000_0080_0000;
  localparam logic signed [63:0] U_CLAMP   = 64'sh0000_0200_0000_0000;
  localparam logic signed [63:0] PIX_MAX   = 64'sd65535;
  localparam logic signed [63:0] PIX_MIN   = -64'sd65536;
  localparam logic [16:0]        PIX_MISS  = 17'h1FFFF;

  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][20:0] n;
    logic [2:0][20:0] r;
    logic [2:0][20:0] u;
    logic [31:0]      inv_w;
    logic [31:0]      inv_h;
    logic [15:0]      pix_w;
    logic [15:0]      pix_h;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][17:0] d;
    logic [30:0]      reach;
    logic [55:0]      mn;
    logic [40:0]      md;
    logic [1:0]       rsn;
  } ray_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][17:0] d;
    logic [30:0]      reach;
    logic [1:0]       rsn;
    logic [40:0]      md;
    logic [40:0]      rem;
    logic [30:0]      nlo;
    logic [30:0]      q;
  } div_t;

  typedef struct packed {
    logic        hit;
    logic [16:0] px;
    logic [16:0] py;
    logic [1:0]  rsn;
  } res_t;

  // round half away from zero, then shift right by k
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned k);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic fits32(input logic signed [63:0] v);
    return (&v[63:31]) | ~(|v[63:31]);
  endfunction

  // one restoring division step: bring down a dividend bit, try subtract
  function automatic div_t div_step(input div_t s);
    div_t        n;
    logic [41:0] r2;
    n  = s;
    r2 = {s.rem, s.nlo[30]};
    n.nlo = {s.nlo[29:0], 1'b0};
    if (r2 >= {1'b0, s.md}) begin
      n.rem = 41'(r2 - {1'b0, s.md});
      n.q   = {s.q[29:0], 1'b1};
    end else begin
      n.rem = r2[40:0];
      n.q   = {s.q[29:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/rpph_front.sv
// ---------------------------------------------------------------------------
// rpph_front: ray intake and classification
// Forms the plane dot products, flags parallel and behind rays and queues
// each item with magnitudes for the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module rpph_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rpph_pkg::cfg_t       cfg_i,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic signed [31:0]   origin_x_i,
  input  wire logic signed [31:0]   origin_y_i,
  input  wire logic signed [31:0]   origin_z_i,
  input  wire logic signed [17:0]   direction_x_i,
  input  wire logic signed [17:0]   direction_y_i,
  input  wire logic signed [17:0]   direction_z_i,
  input  wire logic [30:0]          max_reach_i,
  output logic                      mq_valid_o,
  output rpph_pkg::ray_t            mq_data_o,
  input  wire logic                 mq_take_i
);
  import rpph_pkg::*;

  logic                adv;
  logic                accept;
  logic [2:0][31:0]    in_o;
  logic [2:0][17:0]    in_d;

  logic                f1_v_q;
  logic [2:0][31:0]    f1_o_q;
  logic [2:0][17:0]    f1_d_q;
  logic [30:0]         f1_reach_q;
  logic signed [38:0]  f1_nd_q   [3];
  logic signed [32:0]  f1_diff_q [3];
  logic signed [38:0]  nd_d      [3];
  logic signed [32:0]  diff_d    [3];

  logic                f2_v_q;
  logic [2:0][31:0]    f2_o_q;
  logic [2:0][17:0]    f2_d_q;
  logic [30:0]         f2_reach_q;
  logic signed [40:0]  f2_den_q;
  logic signed [53:0]  f2_dn_q [3];
  logic signed [53:0]  dn_d    [3];
  logic signed [40:0]  den_d;

  logic signed [55:0]  num;
  ray_t                ray;

  ray_t                mem_q [4];
  logic [1:0]          wp_q, rp_q;
  logic [2:0]          cnt_q;
  logic                mq_full;
  logic                mq_push;
  logic                mq_pop;

  assign mq_full = (cnt_q == 3'd4);
  assign adv     = !f2_v_q || !mq_full;
  assign full    = !adv;
  assign accept  = push && adv;

  always_comb begin
    in_o = {origin_z_i, origin_y_i, origin_x_i};
    in_d = {direction_z_i, direction_y_i, direction_x_i};
    for (int i = 0; i < 3; i++) begin
      nd_d[i]   = $signed(in_d[i]) * $signed(cfg_i.n[i]);
      diff_d[i] = 33'($signed(cfg_i.c[i])) - 33'($signed(in_o[i]));
      dn_d[i]   = f1_diff_q[i] * $signed(cfg_i.n[i]);
    end
    den_d = 41'(f1_nd_q[0]) + 41'(f1_nd_q[1]) + 41'(f1_nd_q[2]);
  end

  always_comb begin
    num       = 56'(f2_dn_q[0]) + 56'(f2_dn_q[1]) + 56'(f2_dn_q[2]);
    ray.o     = f2_o_q;
    ray.d     = f2_d_q;
    ray.reach = f2_reach_q;
    ray.mn    = num[55] ? 56'(-num) : 56'(num);
    ray.md    = f2_den_q[40] ? 41'(-f2_den_q) : 41'(f2_den_q);
    priority if (f2_den_q >= -DEN_FLOOR && f2_den_q <= DEN_FLOOR) begin
      ray.rsn = RSN_PARALLEL;
    end else if (num != 56'sd0 && (num[55] != f2_den_q[40])) begin
      ray.rsn = RSN_RANGE;
    end else begin
      ray.rsn = RSN_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= accept;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_o_q     <= in_o;
      f1_d_q     <= in_d;
      f1_reach_q <= max_reach_i;
      f2_o_q     <= f1_o_q;
      f2_d_q     <= f1_d_q;
      f2_reach_q <= f1_reach_q;
      f2_den_q   <= den_d;
      for (int i = 0; i < 3; i++) begin
        f1_nd_q[i]   <= nd_d[i];
        f1_diff_q[i] <= diff_d[i];
        f2_dn_q[i]   <= dn_d[i];
      end
    end
  end

  // queue between front and back
  assign mq_push    = f2_v_q && !mq_full;
  assign mq_pop     = mq_take_i && (cnt_q != 3'd0);
  assign mq_valid_o = (cnt_q != 3'd0);
  assign mq_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (mq_push) wp_q <= wp_q + 2'd1;
      if (mq_pop)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(mq_push) - 3'(mq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mq_push) mem_q[wp_q] <= ray;
  end

endmodule

`default_nettype wire

>>> design/rpph_div.sv
// ---------------------------------------------------------------------------
// rpph_div: pipelined distance divider
// One restoring quotient bit per stage; all stages advance together.
// ---------------------------------------------------------------------------
`default_nettype none

module rpph_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           in_v_i,
  input  wire rpph_pkg::div_t in_i,
  output logic                out_v_o,
  output rpph_pkg::div_t      out_o
);
  import rpph_pkg::*;

  div_t                 st_q [DIV_STEPS];
  div_t                 st_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] v_q;

  always_comb begin
    st_d[0] = div_step(in_i);
    for (int k = 1; k < DIV_STEPS; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DIV_STEPS-2:0], in_v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_v_o = v_q[DIV_STEPS-1];
  assign out_o   = st_q[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> design/rpph_back.sv
// ---------------------------------------------------------------------------
// rpph_back: distance, hit point and pixel mapping
// Divides for the hit distance, builds the hit point, projects it on the
// panel axes, maps to pixels and holds results in a two entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rpph_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rpph_pkg::cfg_t cfg_i,
  input  wire logic           mq_valid_i,
  input  wire rpph_pkg::ray_t mq_data_i,
  output logic                mq_take_o,
  output logic                empty,
  input  wire logic           pop,
  output logic                hit_o,
  output logic signed [16:0]  pixel_x_o,
  output logic signed [16:0]  pixel_y_o,
  output logic [1:0]          miss_reason_o
);
  import rpph_pkg::*;

  logic               adv;
  logic               oq_full;

  logic               b0_v_q;
  div_t               b0_q;
  div_t               b0_d;

  logic               dv_v;
  div_t               dv;

  logic               p1_v_q;
  logic [2:0][31:0]   p1_o_q;
  logic [1:0]         p1_rsn_q;
  logic signed [49:0] p1_dt_q [3];
  logic signed [49:0] dt_d    [3];
  logic [1:0]         rsn1_d;

  logic               p2_v_q;
  logic [1:0]         p2_rsn_q;
  logic signed [32:0] p2_rel_q [3];
  logic signed [32:0] rel_d    [3];
  logic signed [63:0] pos;
  logic [1:0]         rsn2_d;

  logic               p3_v_q;
  logic [1:0]         p3_rsn_q;
  logic signed [53:0] p3_pr_q [3];
  logic signed [53:0] p3_pu_q [3];
  logic signed [53:0] pr_d    [3];
  logic signed [53:0] pu_d    [3];

  logic               p4_v_q;
  logic [1:0]         p4_rsn_q;
  logic signed [31:0] p4_ar_q, p4_au_q;
  logic signed [63:0] ar, au;
  logic [1:0]         rsn4_d;

  logic               p5_v_q;
  logic [1:0]         p5_rsn_q;
  logic signed [63:0] p5_sx_q, p5_sy_q;
  logic signed [64:0] sx_d, sy_d;

  logic               p6_v_q;
  logic [1:0]         p6_rsn_q;
  logic signed [42:0] p6_ux_q, p6_uy_q;
  logic signed [63:0] sx, sy, ux, uy;

  logic               p7_v_q;
  logic [1:0]         p7_rsn_q;
  logic signed [59:0] p7_mx_q, p7_my_q;
  logic signed [59:0] mx_d, my_d;

  logic signed [63:0] px, py;
  res_t               res;

  res_t               oq_q [2];
  logic               owp_q, orp_q;
  logic [1:0]         ocnt_q;
  logic               oq_push, oq_pop;

  assign adv       = !p7_v_q || !oq_full;
  assign mq_take_o = mq_valid_i && adv;

  // divider setup: a quotient of 2^31 or more is always past reach
  always_comb begin
    b0_d.o     = mq_data_i.o;
    b0_d.d     = mq_data_i.d;
    b0_d.reach = mq_data_i.reach;
    b0_d.md    = mq_data_i.md;
    b0_d.rem   = mq_data_i.mn[55:15];
    b0_d.nlo   = {mq_data_i.mn[14:0], 16'd0};
    b0_d.q     = '0;
    if (mq_data_i.rsn == RSN_HIT && mq_data_i.mn >= {mq_data_i.md, 15'd0}) begin
      b0_d.rsn = RSN_RANGE;
    end else begin
      b0_d.rsn = mq_data_i.rsn;
    end
  end

  rpph_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_v_i  (b0_v_q),
    .in_i    (b0_q),
    .out_v_o (dv_v),
    .out_o   (dv)
  );

  always_comb begin
    rsn1_d = (dv.rsn == RSN_HIT && dv.q > dv.reach) ? RSN_RANGE : dv.rsn;
    rsn2_d = p1_rsn_q;
    for (int i = 0; i < 3; i++) begin
      dt_d[i] = $signed(dv.d[i]) * $signed({1'b0, dv.q});
      pos = 64'($signed(p1_o_q[i])) + rnd_shift(64'(p1_dt_q[i]), 16);
      if (!fits32(pos) && rsn2_d == RSN_HIT) rsn2_d = RSN_OVERFLOW;
      rel_d[i] = 33'(pos - 64'($signed(cfg_i.c[i])));
      pr_d[i]  = p2_rel_q[i] * $signed(cfg_i.r[i]);
      pu_d[i]  = p2_rel_q[i] * $signed(cfg_i.u[i]);
    end
    ar = rnd_shift(64'(56'(p3_pr_q[0]) + 56'(p3_pr_q[1]) + 56'(p3_pr_q[2])), 19);
    au = rnd_shift(64'(56'(p3_pu_q[0]) + 56'(p3_pu_q[1]) + 56'(p3_pu_q[2])), 19);
    rsn4_d = p3_rsn_q;
    if ((!fits32(ar) || !fits32(au)) && rsn4_d == RSN_HIT) rsn4_d = RSN_OVERFLOW;
    sx_d = p4_ar_q * $signed({1'b0, cfg_i.inv_w});
    sy_d = p4_au_q * $signed({1'b0, cfg_i.inv_h});
    sx = rnd_shift(p5_sx_q, 16);
    sy = rnd_shift(p5_sy_q, 16);
    ux = sx + HALF_Q24;
    uy = HALF_Q24 - sy;
    if (ux > U_CLAMP) ux = U_CLAMP;
    if (ux < -U_CLAMP) ux = -U_CLAMP;
    if (uy > U_CLAMP) uy = U_CLAMP;
    if (uy < -U_CLAMP) uy = -U_CLAMP;
    mx_d = p6_ux_q * $signed({1'b0, cfg_i.pix_w});
    my_d = p6_uy_q * $signed({1'b0, cfg_i.pix_h});
  end

  // final rounding, saturation and miss override
  always_comb begin
    px = rnd_shift(64'(p7_mx_q), 24);
    py = rnd_shift(64'(p7_my_q), 24);
    if (px > PIX_MAX) px = PIX_MAX;
    if (px < PIX_MIN) px = PIX_MIN;
    if (py > PIX_MAX) py = PIX_MAX;
    if (py < PIX_MIN) py = PIX_MIN;
    res.rsn = p7_rsn_q;
    if (p7_rsn_q == RSN_HIT) begin
      res.hit = 1'b1;
      res.px  = px[16:0];
      res.py  = py[16:0];
    end else begin
      res.hit = 1'b0;
      res.px  = PIX_MISS;
      res.py  = PIX_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
    end else if (adv) begin
      b0_v_q <= mq_take_o;
      p1_v_q <= dv_v;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
      p6_v_q <= p5_v_q;
      p7_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_q     <= b0_d;
      p1_o_q   <= dv.o;
      p1_rsn_q <= rsn1_d;
      p2_rsn_q <= rsn2_d;
      p3_rsn_q <= p2_rsn_q;
      for (int i = 0; i < 3; i++) begin
        p1_dt_q[i]  <= dt_d[i];
        p2_rel_q[i] <= rel_d[i];
        p3_pr_q[i]  <= pr_d[i];
        p3_pu_q[i]  <= pu_d[i];
      end
      p4_rsn_q <= rsn4_d;
      p4_ar_q  <= ar[31:0];
      p4_au_q  <= au[31:0];
      p5_rsn_q <= p4_rsn_q;
      p5_sx_q  <= sx_d[63:0];
      p5_sy_q  <= sy_d[63:0];
      p6_rsn_q <= p5_rsn_q;
      p6_ux_q  <= ux[42:0];
      p6_uy_q  <= uy[42:0];
      p7_rsn_q <= p6_rsn_q;
      p7_mx_q  <= mx_d;
      p7_my_q  <= my_d;
    end
  end

  // result queue
  assign oq_full = (ocnt_q == 2'd2);
  assign oq_push = p7_v_q && !oq_full;
  assign oq_pop  = pop && (ocnt_q != 2'd0);
  assign empty   = (ocnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (oq_push) owp_q <= !owp_q;
      if (oq_pop)  orp_q <= !orp_q;
      ocnt_q <= ocnt_q + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[owp_q] <= res;
  end

  assign hit_o         = oq_q[orp_q].hit;
  assign pixel_x_o     = $signed(oq_q[orp_q].px);
  assign pixel_y_o     = $signed(oq_q[orp_q].py);
  assign miss_reason_o = oq_q[orp_q].rsn;

endmodule

`default_nettype wire

>>> design/ray_plane_pixel_hit.sv
// ---------------------------------------------------------------------------
// ray_plane_pixel_hit: ray against panel plane, mapped to panel pixels
// Holds the panel registers and joins the classifying front to the
// dividing and mapping back through a four entry queue.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          origin_*_i, direction_*_i, max_reach_i
//  result    empty / pop          hit_o, pixel_x_o, pixel_y_o, miss_reason_o
//  config    cfg_we_i             cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained while the result queue has room; on the way
//  through: two front stages, the queue, one setup stage, 31 divider stages
//  (one quotient bit each) and seven mapping stages before the result queue.
//  Reset clears the panel registers and empties both queues.
//  A stalled result freezes the back; the front keeps taking items until
//  the middle queue fills.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_plane_pixel_hit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [3:0]          cfg_idx_i,
  input  wire logic [63:0]         cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [31:0]  origin_x_i,
  input  wire logic signed [31:0]  origin_y_i,
  input  wire logic signed [31:0]  origin_z_i,
  input  wire logic signed [17:0]  direction_x_i,
  input  wire logic signed [17:0]  direction_y_i,
  input  wire logic signed [17:0]  direction_z_i,
  input  wire logic [30:0]         max_reach_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     hit_o,
  output logic signed [16:0]       pixel_x_o,
  output logic signed [16:0]       pixel_y_o,
  output logic [1:0]               miss_reason_o
);
  import rpph_pkg::*;

  cfg_t cfg_q;
  logic mq_valid;
  ray_t mq_data;
  logic mq_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X: cfg_q.c[0] <= cfg_data_i[31:0];
        REG_CENTER_Y: cfg_q.c[1] <= cfg_data_i[31:0];
        REG_CENTER_Z: cfg_q.c[2] <= cfg_data_i[31:0];
        REG_NORMAL:   cfg_q.n    <= cfg_data_i[62:0];
        REG_RIGHT:    cfg_q.r    <= cfg_data_i[62:0];
        REG_UP:       cfg_q.u    <= cfg_data_i[62:0];
        REG_INV_EXT: begin
          cfg_q.inv_w <= cfg_data_i[31:0];
          cfg_q.inv_h <= cfg_data_i[63:32];
        end
        REG_PIX_EXT: begin
          cfg_q.pix_w <= cfg_data_i[15:0];
          cfg_q.pix_h <= cfg_data_i[31:16];
        end
        default: ;
      endcase
    end
  end

  rpph_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push          (push),
    .full          (full),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .origin_z_i    (origin_z_i),
    .direction_x_i (direction_x_i),
    .direction_y_i (direction_y_i),
    .direction_z_i (direction_z_i),
    .max_reach_i   (max_reach_i),
    .mq_valid_o    (mq_valid),
    .mq_data_o     (mq_data),
    .mq_take_i     (mq_take)
  );

  rpph_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .mq_valid_i    (mq_valid),
    .mq_data_i     (mq_data),
    .mq_take_o     (mq_take),
    .empty         (empty),
    .pop           (pop),
    .hit_o         (hit_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .miss_reason_o (miss_reason_o)
  );

endmodule

`default_nettype wire

>>> tb/ray_plane_pixel_hit_tb.sv
// ---------------------------------------------------------------------------
// ray_plane_pixel_hit_tb: self-checking bench for the ray to panel pixel block
// Rays go in through the push/full queue port while a second process pops and
// compares each result against a bit-exact integer predictor of the ray and
// plane intersection. Runs directed rays, several panel settings (extremes
// included), random stalls on both sides and a long result hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_plane_pixel_hit_tb;
  import rpph_pkg::*;

  localparam logic [3:0] REG_NONE        = 4'd9;
  localparam longint     PARALLEL_FLOOR  = 34359;
  localparam longint     HALF_Q24_L      = 64'sd8388608;
  localparam longint     U_LIMIT         = 64'sd2199023255552;
  localparam logic [30:0] REACH_MAX      = 31'h7FFF_FFFF;
  localparam int         MAX_REPORTS     = 10;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [17:0] dx, dy, dz;
    logic [30:0]        reach;
  } ray_item_t;

  typedef struct {
    logic        hit;
    logic [16:0] px;
    logic [16:0] py;
    logic [1:0]  reason;
  } pixel_hit_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [3:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [17:0] direction_x_i = '0, direction_y_i = '0, direction_z_i = '0;
  logic [30:0]        max_reach_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               hit_o;
  logic signed [16:0] pixel_x_o, pixel_y_o;
  logic [1:0]         miss_reason_o;

  // panel mirror
  logic signed [31:0] ctr [3];
  logic [62:0]        nrm_axes, right_axes, up_axes;
  logic [63:0]        inv_ext;
  logic [31:0]        pix_ext;

  pixel_hit_t pending_hits[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  int         pop_hold = 0;

  ray_plane_pixel_hit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full,
    .origin_x_i, .origin_y_i, .origin_z_i,
    .direction_x_i, .direction_y_i, .direction_z_i, .max_reach_i,
    .empty, .pop, .hit_o, .pixel_x_o, .pixel_y_o, .miss_reason_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("ray_plane_pixel_hit_tb NOT OK");
    $finish;
  end

  // ---------------- prediction ----------------
  function automatic longint round_away(longint v, int k);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (k - 1))) >>> k;
    return v < 0 ? -m : m;
  endfunction

  function automatic bit in_int32(longint v);
    return v == longint'(int'(v));
  endfunction

  function automatic longint axis_comp(logic [62:0] packed_axes, int i);
    logic signed [20:0] c;
    c = packed_axes[21*i +: 21];
    return longint'(c);
  endfunction

  function automatic logic [16:0] map_to_pixel(longint a, longint inv, bit mirror,
                                               longint npix);
    longint s, u, px;
    s = round_away(a * inv, 16);
    u = mirror ? HALF_Q24_L - s : s + HALF_Q24_L;
    if (u > U_LIMIT) u = U_LIMIT;
    if (u < -U_LIMIT) u = -U_LIMIT;
    px = round_away(u * npix, 24);
    if (px > 65535) px = 65535;
    if (px < -65536) px = -65536;
    return px[16:0];
  endfunction

  function automatic pixel_hit_t predict_pixel_hit(ray_item_t r);
    pixel_hit_t res;
    longint o[3], d[3], n[3], rel[3];
    longint den, num, mn, md, t, p, ar, au;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    res = '{hit: 1'b0, px: PIX_MISS, py: PIX_MISS, reason: RSN_HIT};
    den = 0;
    num = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = axis_comp(nrm_axes, i);
      den += d[i] * n[i];
      num += (longint'(ctr[i]) - o[i]) * n[i];
    end
    if (den >= -PARALLEL_FLOOR && den <= PARALLEL_FLOOR) begin
      res.reason = RSN_PARALLEL;
      return res;
    end
    if (num != 0 && ((num < 0) != (den < 0))) begin
      res.reason = RSN_RANGE;
      return res;
    end
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    t = ((mn / md) <<< 16) + (((mn % md) <<< 16) / md);
    if (t > longint'(r.reach)) begin
      res.reason = RSN_RANGE;
      return res;
    end
    ar = 0;
    au = 0;
    for (int i = 0; i < 3; i++) begin
      p = o[i] + round_away(d[i] * t, 16);
      if (!in_int32(p)) begin
        res.reason = RSN_OVERFLOW;
        return res;
      end
      rel[i] = p - longint'(ctr[i]);
      ar += rel[i] * axis_comp(right_axes, i);
      au += rel[i] * axis_comp(up_axes, i);
    end
    ar = round_away(ar, 19);
    au = round_away(au, 19);
    if (!in_int32(ar) || !in_int32(au)) begin
      res.reason = RSN_OVERFLOW;
      return res;
    end
    res.hit = 1'b1;
    res.px = map_to_pixel(ar, longint'(inv_ext[31:0]), 1'b0, longint'(pix_ext[15:0]));
    res.py = map_to_pixel(au, longint'(inv_ext[63:32]), 1'b1, longint'(pix_ext[31:16]));
    return res;
  endfunction

  // ---------------- result side ----------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (pop_hold > 0) begin
        pop_hold--;
        pop = 1'b0;
      end else begin
        pop = calm || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: hit %0b px %0d py %0d reason %0d",
                   hit_o, pixel_x_o, pixel_y_o, miss_reason_o);
      end else begin
        pixel_hit_t e;
        e = pending_hits.pop_front();
        if (hit_o !== e.hit || pixel_x_o !== e.px || pixel_y_o !== e.py ||
            miss_reason_o !== e.reason) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected hit %0b px %0d py %0d reason %0d, got %0b %0d %0d %0d",
                     e.hit, $signed(e.px), $signed(e.py), e.reason,
                     hit_o, pixel_x_o, pixel_y_o, miss_reason_o);
        end
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_ray(ray_item_t r);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 29) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    origin_x_i = r.ox; origin_y_i = r.oy; origin_z_i = r.oz;
    direction_x_i = r.dx; direction_y_i = r.dy; direction_z_i = r.dz;
    max_reach_i = r.reach;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    pending_hits.insert(pending_hits.size(), predict_pixel_hit(r));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_CENTER_X: ctr[0] = data[31:0];
      REG_CENTER_Y: ctr[1] = data[31:0];
      REG_CENTER_Z: ctr[2] = data[31:0];
      REG_NORMAL:   nrm_axes = data[62:0];
      REG_RIGHT:    right_axes = data[62:0];
      REG_UP:       up_axes = data[62:0];
      REG_INV_EXT:  inv_ext = data;
      REG_PIX_EXT:  pix_ext = data[31:0];
      default: ;
    endcase
  endtask

  function automatic logic [62:0] pack_axes(int x, int y, int z);
    logic [20:0] a, b, c;
    a = x[20:0]; b = y[20:0]; c = z[20:0];
    return {c, b, a};
  endfunction

  task automatic load_panel(int cx, int cy, int cz, logic [62:0] n, logic [62:0] rt,
                            logic [62:0] up, logic [63:0] inv, logic [31:0] pix);
    write_reg(REG_CENTER_X, 64'(signed'(cx)));
    write_reg(REG_CENTER_Y, 64'(signed'(cy)));
    write_reg(REG_CENTER_Z, 64'(signed'(cz)));
    write_reg(REG_NORMAL, {1'b0, n});
    write_reg(REG_RIGHT, {1'b0, rt});
    write_reg(REG_UP, {1'b0, up});
    write_reg(REG_INV_EXT, inv);
    write_reg(REG_PIX_EXT, {32'd0, pix});
  endtask

  task automatic load_standard_panel();
    load_panel(0, 0, 409600, pack_axes(0, 0, 524288), pack_axes(524288, 0, 0),
               pack_axes(0, 524288, 0), {32'd67108864, 32'd67108864},
               {16'd1080, 16'd1920});
  endtask

  function automatic ray_item_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       logic [30:0] reach);
    ray_item_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx[17:0]; r.dy = dy[17:0]; r.dz = dz[17:0];
    r.reach = reach;
    return r;
  endfunction

  function automatic int signed_rand(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // mostly rays aimed roughly at the panel; the rest raw noise
  function automatic ray_item_t random_ray();
    ray_item_t r;
    int dz;
    if ($urandom_range(99) < 20) begin
      r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 31'($urandom));
    end else begin
      r = mk_ray(signed_rand(1 << 22), signed_rand(1 << 22), signed_rand(1 << 22),
                 signed_rand(1 << 14), signed_rand(1 << 14), 0, REACH_MAX);
      dz = $urandom_range(131071, 8192);
      // point toward the plane most of the time if the normal's z part is not negative, else away
      if ((ctr[2] < r.oz) != (axis_comp(nrm_axes, 2) < 0) ^ ($urandom_range(99) < 15))
        dz = -dz;
      r.dz = dz[17:0];
      if ($urandom_range(99) < 20) r.reach = 31'($urandom);
    end
    return r;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    load_standard_panel();
    send_ray(mk_ray(0, 0, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 65536, 0, 0, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 0, 0, -65536, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 0, 0, 65536, 100));
    send_ray(mk_ray(0, 0, 409600, 0, 0, 65536, 0));
    send_ray(mk_ray(4096, 4096, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(-8192, 8192, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(2048, -2048, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 131071, 0, 16, REACH_MAX));
    send_ray(mk_ray(4096000, 0, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(-4096000, -4096000, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, -131072, -131072, -131072, REACH_MAX));
    send_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    131071, 131071, 131071, REACH_MAX));
    send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    -131072, 131071, 131071, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 0, 0, 1, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 30000, -30000, 65536, REACH_MAX));
    send_ray(mk_ray(0, 0, 0, 0, 0, 65536, 409600));
    send_ray(mk_ray(0, 0, 0, 0, 0, 65536, 409599));
    drain_results();
  endtask

  task automatic test_zero_scale();
    write_reg(REG_INV_EXT, 64'd0);
    write_reg(REG_PIX_EXT, {32'd0, 16'd1080, 16'd0});
    send_ray(mk_ray(0, 0, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(40960, -40960, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(-4096000, 4096000, 0, 0, 0, 65536, REACH_MAX));
    drain_results();
  endtask

  task automatic test_random_panels();
    for (int k = 0; k < 6; k++) begin
      int nz;
      nz = $urandom_range(1048575, 131072);
      if ($urandom_range(1)) nz = -nz;
      load_panel(signed_rand(1 << 24), signed_rand(1 << 24), signed_rand(1 << 24),
                 pack_axes(signed_rand(1 << 16), signed_rand(1 << 16), nz),
                 pack_axes(signed_rand(1 << 20), signed_rand(1 << 20), signed_rand(1 << 18)),
                 pack_axes(signed_rand(1 << 20), signed_rand(1 << 20), signed_rand(1 << 18)),
                 {$urandom_range(1 << 28, 1 << 18), $urandom_range(1 << 28, 1 << 18)},
                 $urandom);
      calm = (k == 3);
      for (int i = 0; i < 70; i++) send_ray(random_ray());
      calm = 1'b0;
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    load_standard_panel();
    pop_hold = 400;
    calm = 1'b1;
    for (int i = 0; i < 60; i++) send_ray(random_ray());
    calm = 1'b0;
    drain_results();
  endtask

  task automatic test_extremes();
    load_panel(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               pack_axes(21'h0F_FFFF, 21'h0F_FFFF, 21'h0F_FFFF),
               pack_axes(21'h10_0000, 21'h10_0000, 21'h10_0000),
               pack_axes(21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF),
               64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 30; i++) send_ray(random_ray());
    drain_results();
    load_panel(0, 0, 409600, pack_axes(0, 0, 524288),
               pack_axes(21'h10_0000, 21'h10_0000, 21'h10_0000),
               pack_axes(21'h10_0000, 0, 0), 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_ray(mk_ray(32'h7FFF_0000, 0, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(4096, 0, 0, 0, 0, 65536, REACH_MAX));
    send_ray(mk_ray(-4096, 0, 0, 0, 0, 65536, REACH_MAX));
    for (int i = 0; i < 30; i++) send_ray(random_ray());
    drain_results();
  endtask

  task automatic test_unused_register();
    load_standard_panel();
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 30; i++) send_ray(random_ray());
    drain_results();
  endtask

  initial begin
    ctr[0] = '0; ctr[1] = '0; ctr[2] = '0;
    nrm_axes = '0; right_axes = '0; up_axes = '0;
    inv_ext = '0; pix_ext = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_zero_scale();
    test_random_panels();
    test_backpressure();
    test_extremes();
    test_unused_register();
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("ray_plane_pixel_hit_tb OK");
    end else begin
      $display("ray_plane_pixel_hit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/rpph_pkg.sv
design/rpph_front.sv
design/rpph_div.sv
design/rpph_back.sv
design/ray_plane_pixel_hit.sv
tb/ray_plane_pixel_hit_tb.sv
